/* rtl/core/tgi_pkg.sv */
// Shared types and constants of the trilinear grid interpolator.
package tgi_pkg;

    typedef enum logic [2:0] {
        CMD_LOAD_X    = 3'd0,
        CMD_LOAD_Y    = 3'd1,
        CMD_LOAD_Z    = 3'd2,
        CMD_LOAD_CELL = 3'd3,
        CMD_QUERY     = 3'd4
    } cmd_t;

    localparam logic [1:0] REG_X_POINTS = 2'd0;
    localparam logic [1:0] REG_Y_POINTS = 2'd1;
    localparam logic [1:0] REG_Z_POINTS = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam int          FRAC_BITS  = 16;
    localparam logic [16:0] FRAC_ONE   = 17'h10000;
    localparam logic [2:0]  LAST_CORNER = 3'd7;
    localparam logic [2:0]  LAST_BLEND  = 3'd6;

    typedef enum logic [1:0] {
        OP_AXIS,
        OP_CELL,
        OP_QUERY
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [1:0]         axis;
        logic [3:0]         idx_i;
        logic [3:0]         idx_j;
        logic [3:0]         idx_k;
        logic signed [31:0] value;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic signed [31:0] qz;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLAMP_HI,
        S_CLAMP_LO,
        S_SEARCH,
        S_FHI,
        S_FLO,
        S_DIV,
        S_TRD,
        S_TWR,
        S_MUL,
        S_ADD,
        S_OUT
    } state_t;

    function automatic logic [8:0] eff_count(input logic [4:0] r, input logic [8:0] maxp);
        logic [8:0] v;
        v = {4'd0, r};
        if (v < 9'd2)
            v = 9'd2;
        if (v > maxp)
            v = maxp;
        return v;
    endfunction

endpackage

/* rtl/core/tgi_if.sv */
// Channel interfaces of the trilinear grid interpolator.
interface tgi_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic [3:0]         index_i;
    logic [3:0]         index_j;
    logic [3:0]         index_k;
    logic signed [31:0] load_value;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
    logic signed [31:0] query_z;
    modport source (output valid, command, index_i, index_j, index_k, load_value,
                    query_x, query_y, query_z, input ready);
    modport sink (input valid, command, index_i, index_j, index_k, load_value,
                  query_x, query_y, query_z, output ready);
endinterface

interface tgi_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] interp_value;
    modport source (output valid, interp_value, input ready);
    modport sink (input valid, interp_value, output ready);
endinterface

interface tgi_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [4:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/trilinear_grid_interpolator_unit.sv */
// Each axis runs the clamp, the binary search, the bound reads and, when the fraction lies
// strictly between 0 and 1, the bit-serial divider; the corners are then fetched and blended.
// The back end sequencer runs one query at a time; a load is written from the queue while the
// sequencer is idle, and loads follow at one per cycle while it stays idle.
// Reset clears control state and sets all point counts to 16; stores are undefined until written.
// Top level of the trilinear grid interpolator.
module trilinear_grid_interpolator_unit
    import tgi_pkg::*;
#(
    parameter int MAX_X_POINTS = 16,
    parameter int MAX_Y_POINTS = 16,
    parameter int MAX_Z_POINTS = 16
)
(
    input logic       clk,
    input logic       rst_n,
    tgi_in_if.sink    req,
    tgi_cfg_if.sink   cfg,
    tgi_out_if.source rsp
);

    localparam int MAXXY = (MAX_X_POINTS > MAX_Y_POINTS) ? MAX_X_POINTS : MAX_Y_POINTS;
    localparam int MAXP  = (MAXXY > MAX_Z_POINTS) ? MAXXY : MAX_Z_POINTS;
    localparam int NW    = $clog2(MAXP + 1);

    logic          push;
    entry_t        push_data;
    logic          full;
    logic          pop;
    logic          empty;
    entry_t        head;
    logic [NW-1:0] nx;
    logic [NW-1:0] ny;
    logic [NW-1:0] nz;

    tgi_front #(
        .MAX_X_POINTS(MAX_X_POINTS),
        .MAX_Y_POINTS(MAX_Y_POINTS),
        .MAX_Z_POINTS(MAX_Z_POINTS),
        .NW(NW)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .cfg(cfg),
        .full(full),
        .push(push),
        .push_data(push_data),
        .nx(nx),
        .ny(ny),
        .nz(nz)
    );

    tgi_fifo u_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_data(push_data),
        .full(full),
        .pop(pop),
        .empty(empty),
        .head(head)
    );

    tgi_back #(
        .MAX_X_POINTS(MAX_X_POINTS),
        .MAX_Y_POINTS(MAX_Y_POINTS),
        .MAX_Z_POINTS(MAX_Z_POINTS),
        .NW(NW)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .empty(empty),
        .head(head),
        .pop(pop),
        .nx(nx),
        .ny(ny),
        .nz(nz),
        .rsp(rsp)
    );

endmodule

/* rtl/core/tgi_front.sv */
// Front end: input acceptance, command classification and point count registers.
module tgi_front
    import tgi_pkg::*;
#(
    parameter int MAX_X_POINTS = 16,
    parameter int MAX_Y_POINTS = 16,
    parameter int MAX_Z_POINTS = 16,
    parameter int NW           = 5
)
(
    input  logic          clk,
    input  logic          rst_n,
    tgi_in_if.sink        req,
    tgi_cfg_if.sink       cfg,
    input  logic          full,
    output logic          push,
    output entry_t        push_data,
    output logic [NW-1:0] nx,
    output logic [NW-1:0] ny,
    output logic [NW-1:0] nz
);

    logic [4:0] x_points_reg;
    logic [4:0] y_points_reg;
    logic [4:0] z_points_reg;
    logic       keep;
    logic [8:0] ex;
    logic [8:0] ey;
    logic [8:0] ez;

    assign cfg.ready = 1'b1;
    assign req.ready = !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_points_reg <= 5'd16;
            y_points_reg <= 5'd16;
            z_points_reg <= 5'd16;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_X_POINTS)
                x_points_reg <= cfg.data;
            if (cfg.index == REG_Y_POINTS)
                y_points_reg <= cfg.data;
            if (cfg.index == REG_Z_POINTS)
                z_points_reg <= cfg.data;
        end
    end

    assign ex = eff_count(x_points_reg, 9'(MAX_X_POINTS));
    assign ey = eff_count(y_points_reg, 9'(MAX_Y_POINTS));
    assign ez = eff_count(z_points_reg, 9'(MAX_Z_POINTS));
    assign nx = ex[NW-1:0];
    assign ny = ey[NW-1:0];
    assign nz = ez[NW-1:0];

    // Out of range loads and unknown commands are dropped here.
    always_comb
    begin
        push_data.axis  = req.command[1:0];
        push_data.idx_i = req.index_i;
        push_data.idx_j = req.index_j;
        push_data.idx_k = req.index_k;
        push_data.value = req.load_value;
        push_data.qx    = req.query_x;
        push_data.qy    = req.query_y;
        push_data.qz    = req.query_z;
        push_data.op    = OP_QUERY;
        keep            = 1'b0;
        unique case (req.command)
            CMD_LOAD_X:
            begin
                push_data.op = OP_AXIS;
                keep = int'(req.index_i) < MAX_X_POINTS;
            end
            CMD_LOAD_Y:
            begin
                push_data.op = OP_AXIS;
                keep = int'(req.index_i) < MAX_Y_POINTS;
            end
            CMD_LOAD_Z:
            begin
                push_data.op = OP_AXIS;
                keep = int'(req.index_i) < MAX_Z_POINTS;
            end
            CMD_LOAD_CELL:
            begin
                push_data.op = OP_CELL;
                keep = (int'(req.index_i) < MAX_X_POINTS) && (int'(req.index_j) < MAX_Y_POINTS)
                    && (int'(req.index_k) < MAX_Z_POINTS);
            end
            CMD_QUERY:
            begin
                keep = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
        push = req.valid && !full && keep;
    end

endmodule

/* rtl/core/tgi_fifo.sv */
// Short command queue between the front end and the back end.
module tgi_fifo
    import tgi_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   empty,
    output entry_t head
);

    entry_t     slot_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;

    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign head  = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= !wptr_reg;
            if (pop)
                rptr_reg <= !rptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

/* rtl/core/tgi_back.sv */
// Back end: axis and cell store writes, axis search, fraction division, corner fetch and blend sequencer.
module tgi_back
    import tgi_pkg::*;
#(
    parameter int MAX_X_POINTS = 16,
    parameter int MAX_Y_POINTS = 16,
    parameter int MAX_Z_POINTS = 16,
    parameter int NW           = 5
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          empty,
    input  entry_t        head,
    output logic          pop,
    input  logic [NW-1:0] nx,
    input  logic [NW-1:0] ny,
    input  logic [NW-1:0] nz,
    tgi_out_if.source     rsp
);

    localparam int MAXXY = (MAX_X_POINTS > MAX_Y_POINTS) ? MAX_X_POINTS : MAX_Y_POINTS;
    localparam int MAXP  = (MAXXY > MAX_Z_POINTS) ? MAXXY : MAX_Z_POINTS;
    localparam int AB    = $clog2(MAXP);
    localparam int XB    = $clog2(MAX_X_POINTS);
    localparam int YB    = $clog2(MAX_Y_POINTS);
    localparam int ZB    = $clog2(MAX_Z_POINTS);
    localparam int TAB   = XB + YB + ZB;

    logic signed [31:0] axis_mem [3 * (2 ** AB)];
    logic signed [31:0] table_mem [2 ** TAB];

    state_t             state_reg, state_next;
    logic [1:0]         ax_reg, ax_next;
    logic signed [31:0] q_reg [3];
    logic signed [31:0] q_next [3];
    logic signed [31:0] qcur_reg, qcur_next;
    logic [NW-1:0]      lo_reg, lo_next;
    logic [NW-1:0]      cnt_reg, cnt_next;
    logic [AB-1:0]      hi_reg [3];
    logic [AB-1:0]      hi_next [3];
    logic [16:0]        frac_reg [3];
    logic [16:0]        frac_next [3];
    logic signed [31:0] ahi_reg, ahi_next;
    logic [33:0]        rem_reg, rem_next;
    logic [32:0]        den_reg, den_next;
    logic [15:0]        quo_reg, quo_next;
    logic [3:0]         bit_reg, bit_next;
    logic [2:0]         corner_reg, corner_next;
    logic signed [31:0] w_reg [8];
    logic signed [31:0] w_next [8];
    logic [3:0]         tail_reg, tail_next;
    logic [2:0]         step_reg, step_next;
    logic signed [50:0] prod_reg, prod_next;
    logic signed [31:0] base_reg, base_next;
    logic signed [31:0] result_reg, result_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_data_reg, out_data_next;

    logic signed [31:0] ax_rdata_reg;
    logic signed [31:0] tbl_rdata_reg;
    logic               ax_re;
    logic [AB+1:0]      ax_raddr;
    logic               ax_we;
    logic [AB+1:0]      ax_waddr;
    logic               tbl_re;
    logic [TAB-1:0]     tbl_raddr;
    logic               tbl_we;
    logic [TAB-1:0]     tbl_waddr;

    logic [NW-1:0]      n_cur;
    logic [NW-1:0]      n_nxt;
    logic [NW-1:0]      step_w;
    logic [NW-1:0]      u_w;
    logic [NW-1:0]      cnt_w;
    logic [NW-1:0]      lo_w;
    logic signed [32:0] num_w;
    logic signed [32:0] den_w;
    logic [33:0]        r2_w;
    logic               axis_done;
    logic [16:0]        frac_w;
    logic [16:0]        f_w;
    logic signed [32:0] diff_w;
    logic signed [50:0] adj_w;
    logic signed [31:0] res_w;
    logic [AB-1:0]      xi_w;
    logic [AB-1:0]      yi_w;
    logic [AB-1:0]      zi_w;
    logic [7:0]         ii_w;
    logic [7:0]         jj_w;
    logic [7:0]         kk_w;

    always_ff @(posedge clk)
    begin
        if (ax_we)
            axis_mem[ax_waddr] <= head.value;
        if (ax_re)
            ax_rdata_reg <= axis_mem[ax_raddr];
        if (tbl_we)
            table_mem[tbl_waddr] <= head.value;
        if (tbl_re)
            tbl_rdata_reg <= table_mem[tbl_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            ax_reg        <= AXIS_X;
            tail_reg      <= 4'd0;
            step_reg      <= 3'd0;
            corner_reg    <= 3'd0;
            bit_reg       <= 4'd0;
            lo_reg        <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            ax_reg        <= ax_next;
            tail_reg      <= tail_next;
            step_reg      <= step_next;
            corner_reg    <= corner_next;
            bit_reg       <= bit_next;
            lo_reg        <= lo_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg        <= q_next;
        qcur_reg     <= qcur_next;
        hi_reg       <= hi_next;
        frac_reg     <= frac_next;
        ahi_reg      <= ahi_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        quo_reg      <= quo_next;
        w_reg        <= w_next;
        prod_reg     <= prod_next;
        base_reg     <= base_next;
        result_reg   <= result_next;
        out_data_reg <= out_data_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.interp_value = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        ax_next        = ax_reg;
        q_next         = q_reg;
        qcur_next      = qcur_reg;
        lo_next        = lo_reg;
        cnt_next       = cnt_reg;
        hi_next        = hi_reg;
        frac_next      = frac_reg;
        ahi_next       = ahi_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        quo_next       = quo_reg;
        bit_next       = bit_reg;
        corner_next    = corner_reg;
        w_next         = w_reg;
        tail_next      = tail_reg;
        step_next      = step_reg;
        prod_next      = prod_reg;
        base_next      = base_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        ax_re          = 1'b0;
        ax_raddr       = '0;
        ax_we          = 1'b0;
        tbl_re         = 1'b0;
        tbl_we         = 1'b0;
        axis_done      = 1'b0;
        frac_w         = 17'd0;
        ii_w           = {4'd0, head.idx_i};
        jj_w           = {4'd0, head.idx_j};
        kk_w           = {4'd0, head.idx_k};
        ax_waddr       = {head.axis, ii_w[AB-1:0]};
        tbl_waddr      = {ii_w[XB-1:0], jj_w[YB-1:0], kk_w[ZB-1:0]};

        unique case (ax_reg)
            AXIS_X:  n_cur = nx;
            AXIS_Y:  n_cur = ny;
            default: n_cur = nz;
        endcase
        n_nxt  = (ax_reg == AXIS_X) ? ny : nz;
        step_w = cnt_reg >> 1;
        lo_w   = lo_reg;
        cnt_w  = step_w;
        if (!(qcur_reg < ax_rdata_reg))
        begin
            lo_w  = lo_reg + step_w + NW'(1);
            cnt_w = cnt_reg - step_w - NW'(1);
        end
        u_w = lo_w;
        if (u_w >= n_cur)
            u_w = n_cur - NW'(1);
        if (u_w < NW'(1))
            u_w = NW'(1);
        num_w = 33'(qcur_reg) - 33'(ax_rdata_reg);
        den_w = 33'(ahi_reg) - 33'(ax_rdata_reg);
        r2_w  = {rem_reg[32:0], 1'b0};

        if (step_reg < 3'd4)
            f_w = frac_reg[0];
        else if (step_reg < LAST_BLEND)
            f_w = frac_reg[1];
        else
            f_w = frac_reg[2];
        diff_w = 33'(w_reg[1]) - 33'(w_reg[0]);
        adj_w  = prod_reg + (prod_reg[50] ? 51'sd65535 : 51'sd0);
        res_w  = base_reg + adj_w[47:16];

        xi_w = corner_reg[0] ? hi_reg[0] : hi_reg[0] - AB'(1);
        yi_w = corner_reg[1] ? hi_reg[1] : hi_reg[1] - AB'(1);
        zi_w = corner_reg[2] ? hi_reg[2] : hi_reg[2] - AB'(1);
        tbl_raddr = {xi_w[XB-1:0], yi_w[YB-1:0], zi_w[ZB-1:0]};

        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    unique case (head.op)
                        OP_AXIS: ax_we = 1'b1;
                        OP_CELL: tbl_we = 1'b1;
                        default:
                        begin
                            q_next[0]  = head.qx;
                            q_next[1]  = head.qy;
                            q_next[2]  = head.qz;
                            qcur_next  = head.qx;
                            ax_next    = AXIS_X;
                            ax_re      = 1'b1;
                            ax_raddr   = {AXIS_X, AB'(nx - NW'(1))};
                            state_next = S_CLAMP_HI;
                        end
                    endcase
                end
            end
            S_CLAMP_HI:
            begin
                if (qcur_reg > ax_rdata_reg)
                    qcur_next = ax_rdata_reg;
                ax_re      = 1'b1;
                ax_raddr   = {ax_reg, AB'(0)};
                state_next = S_CLAMP_LO;
            end
            S_CLAMP_LO:
            begin
                if (qcur_reg < ax_rdata_reg)
                    qcur_next = ax_rdata_reg;
                lo_next    = '0;
                cnt_next   = n_cur;
                ax_re      = 1'b1;
                ax_raddr   = {ax_reg, AB'(n_cur >> 1)};
                state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                lo_next  = lo_w;
                cnt_next = cnt_w;
                ax_re    = 1'b1;
                if (cnt_w != '0)
                begin
                    ax_raddr = {ax_reg, AB'(lo_w + (cnt_w >> 1))};
                end
                else
                begin
                    ax_raddr        = {ax_reg, AB'(u_w)};
                    hi_next[ax_reg] = AB'(u_w);
                    state_next      = S_FHI;
                end
            end
            S_FHI:
            begin
                ahi_next   = ax_rdata_reg;
                ax_re      = 1'b1;
                ax_raddr   = {ax_reg, hi_reg[ax_reg] - AB'(1)};
                state_next = S_FLO;
            end
            S_FLO:
            begin
                if ((num_w <= 0) || (den_w <= 0))
                begin
                    axis_done = 1'b1;
                end
                else if (num_w >= den_w)
                begin
                    axis_done = 1'b1;
                    frac_w    = FRAC_ONE;
                end
                else
                begin
                    rem_next   = {1'b0, num_w};
                    den_next   = den_w;
                    bit_next   = 4'd0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // One quotient bit per cycle by restoring division.
                if (r2_w >= {1'b0, den_reg})
                begin
                    rem_next = r2_w - {1'b0, den_reg};
                    quo_next = {quo_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_next = r2_w;
                    quo_next = {quo_reg[14:0], 1'b0};
                end
                bit_next = bit_reg + 4'd1;
                if (bit_reg == 4'(FRAC_BITS - 1))
                begin
                    axis_done = 1'b1;
                    frac_w    = {1'b0, quo_next};
                end
            end
            S_TRD:
            begin
                tbl_re     = 1'b1;
                state_next = S_TWR;
            end
            S_TWR:
            begin
                w_next[tail_reg[2:0]] = tbl_rdata_reg;
                tail_next   = tail_reg + 4'd1;
                corner_next = corner_reg + 3'd1;
                step_next   = 3'd0;
                state_next  = (corner_reg == LAST_CORNER) ? S_MUL : S_TRD;
            end
            S_MUL:
            begin
                prod_next = diff_w * $signed({1'b0, f_w});
                base_next = w_reg[0];
                for (int i = 0; i < 6; i++)
                    w_next[i] = w_reg[i + 2];
                tail_next  = tail_reg - 4'd2;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if (step_reg == LAST_BLEND)
                begin
                    result_next = res_w;
                    state_next  = S_OUT;
                end
                else
                begin
                    w_next[tail_reg[2:0]] = res_w;
                    tail_next  = tail_reg + 4'd1;
                    step_next  = step_reg + 3'd1;
                    state_next = S_MUL;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = result_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (axis_done)
        begin
            frac_next[ax_reg] = frac_w;
            if (ax_reg == AXIS_Z)
            begin
                corner_next = 3'd0;
                tail_next   = 4'd0;
                state_next  = S_TRD;
            end
            else
            begin
                ax_next    = ax_reg + 2'd1;
                qcur_next  = q_reg[ax_reg + 2'd1];
                ax_re      = 1'b1;
                ax_raddr   = {ax_reg + 2'd1, AB'(n_nxt - NW'(1))};
                state_next = S_CLAMP_HI;
            end
        end
    end

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < {den_reg, 1'b0})
        else $error("division remainder out of bound");
    a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= 4'd8)
        else $error("blend operand line overflow");
    a_search_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEARCH |-> cnt_reg != '0)
        else $error("search step with empty range");

endmodule

/* test/tgi_checker.sv */
// Scoreboard for the trilinear grid interpolator: predicts each query result and compares it.
`timescale 1ns / 100ps
module tgi_checker
    import tgi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    tgi_in_if    req,
    tgi_cfg_if   cfg,
    tgi_out_if   rsp,
    output int   fail_count,
    output int   pending_count
);

    longint          axis_store [3][16];
    longint          cell_store [4096];
    logic [4:0]      points_used [3];
    logic [31:0]     expected_values [$];

    function automatic int points_in_use(input int ax);
        int n;
        n = points_used[ax];
        if (n < 2)
            n = 2;
        if (n > 16)
            n = 16;
        return n;
    endfunction

    function automatic void find_cell(input int ax, input longint q, output int hi,
                                      output longint frac);
        int     n;
        int     lo;
        int     count;
        int     half;
        longint num;
        longint den;
        n = points_in_use(ax);
        if (q > axis_store[ax][n - 1])
            q = axis_store[ax][n - 1];
        if (q < axis_store[ax][0])
            q = axis_store[ax][0];
        lo = 0;
        count = n;
        while (count > 0)
        begin
            half = count / 2;
            if (!(q < axis_store[ax][lo + half]))
            begin
                lo = lo + half + 1;
                count = count - half - 1;
            end
            else
                count = half;
        end
        hi = lo;
        if (hi >= n)
            hi = n - 1;
        if (hi < 1)
            hi = 1;
        num = q - axis_store[ax][hi - 1];
        den = axis_store[ax][hi] - axis_store[ax][hi - 1];
        if (num <= 0 || den <= 0)
            frac = 0;
        else if (num >= den)
            frac = 65536;
        else
            frac = (num * 65536) / den;
    endfunction

    function automatic longint mix(input longint a, input longint b, input longint f);
        return a + ((b - a) * f) / 65536;
    endfunction

    function automatic longint corner(input int i, input int j, input int k);
        return cell_store[(i * 16 + j) * 16 + k];
    endfunction

    function automatic logic [31:0] interpolate(input logic signed [31:0] qx,
                                                input logic signed [31:0] qy,
                                                input logic signed [31:0] qz);
        int     xh;
        int     yh;
        int     zh;
        longint fx;
        longint fy;
        longint fz;
        longint c00;
        longint c01;
        longint c10;
        longint c11;
        longint c0;
        longint c1;
        longint c;
        find_cell(0, longint'(qx), xh, fx);
        find_cell(1, longint'(qy), yh, fy);
        find_cell(2, longint'(qz), zh, fz);
        c00 = mix(corner(xh - 1, yh - 1, zh - 1), corner(xh, yh - 1, zh - 1), fx);
        c01 = mix(corner(xh - 1, yh - 1, zh), corner(xh, yh - 1, zh), fx);
        c10 = mix(corner(xh - 1, yh, zh - 1), corner(xh, yh, zh - 1), fx);
        c11 = mix(corner(xh - 1, yh, zh), corner(xh, yh, zh), fx);
        c0 = mix(c00, c10, fy);
        c1 = mix(c01, c11, fy);
        c = mix(c0, c1, fz);
        return c[31:0];
    endfunction

    assign pending_count = expected_values.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_used[0] <= 5'd16;
            points_used[1] <= 5'd16;
            points_used[2] <= 5'd16;
            fail_count <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_X_POINTS: points_used[0] <= cfg.data;
                    REG_Y_POINTS: points_used[1] <= cfg.data;
                    REG_Z_POINTS: points_used[2] <= cfg.data;
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
            begin
                case (req.command)
                    CMD_LOAD_X: axis_store[0][req.index_i] = longint'(req.load_value);
                    CMD_LOAD_Y: axis_store[1][req.index_i] = longint'(req.load_value);
                    CMD_LOAD_Z: axis_store[2][req.index_i] = longint'(req.load_value);
                    CMD_LOAD_CELL:
                        cell_store[{req.index_i, req.index_j, req.index_k}] =
                            longint'(req.load_value);
                    CMD_QUERY:
                        expected_values.push_back(interpolate(req.query_x, req.query_y,
                                                              req.query_z));
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_values.size() == 0)
                begin
                    $display("%0t: result with no query pending, expected none, actual %h",
                             $realtime, rsp.interp_value);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    if (rsp.interp_value !== expected_values[0])
                    begin
                        $display("%0t: interp_value expected %h, actual %h", $realtime,
                                 expected_values[0], rsp.interp_value);
                        fail_count <= fail_count + 1;
                    end
                    void'(expected_values.pop_front());
                end
            end
        end
    end

endmodule

/* test/tb.sv */
// Stimulus and verdict for the trilinear grid interpolator.
`timescale 1ns / 100ps
module tb
    import tgi_pkg::*;
();

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] CMD_MID_UNUSED = 3'd6;
    localparam logic [2:0] CMD_LAST_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int PHASES = 10;

    logic clk;
    logic rst_n;
    logic calm;
    int   fail_count;
    int   pending_count;
    int   cycle_count;
    logic [31:0] axis_copy [3][16];

    tgi_in_if  req_if ();
    tgi_cfg_if cfg_if ();
    tgi_out_if rsp_if ();

    trilinear_grid_interpolator_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .cfg   (cfg_if),
        .rsp   (rsp_if)
    );

    tgi_checker scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_if),
        .cfg           (cfg_if),
        .rsp           (rsp_if),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(negedge clk)
    begin
        rsp_if.ready <= calm || ($urandom_range(0, 99) >= 10);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send(input logic [2:0] c, input logic [3:0] i, input logic [3:0] j,
                        input logic [3:0] k, input logic [31:0] v, input logic [31:0] qx,
                        input logic [31:0] qy, input logic [31:0] qz);
        if (!calm && $urandom_range(0, 99) < 10)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.command <= c;
        req_if.index_i <= i;
        req_if.index_j <= j;
        req_if.index_k <= k;
        req_if.load_value <= v;
        req_if.query_x <= qx;
        req_if.query_y <= qy;
        req_if.query_z <= qz;
        forever
        begin
            #1;
            if (req_if.ready)
                break;
            @(negedge clk);
        end
        @(negedge clk);
    endtask

    task automatic load(input logic [2:0] c, input logic [3:0] i, input logic [3:0] j,
                        input logic [3:0] k, input logic [31:0] v);
        if (c == CMD_LOAD_X)
            axis_copy[0][i] = v;
        if (c == CMD_LOAD_Y)
            axis_copy[1][i] = v;
        if (c == CMD_LOAD_Z)
            axis_copy[2][i] = v;
        send(c, i, j, k, v, $urandom, $urandom, $urandom);
    endtask

    task automatic query(input logic [31:0] qx, input logic [31:0] qy, input logic [31:0] qz);
        send(CMD_QUERY, $urandom, $urandom, $urandom, $urandom, qx, qy, qz);
    endtask

    // Shape 0 is increasing with some equal neighbors, 1 spans the full range, 2 is unsorted.
    task automatic fill_axis(input int ax, input int shape);
        logic [2:0]  c;
        logic [31:0] v;
        int          n;
        c = (ax == 0) ? CMD_LOAD_X : (ax == 1) ? CMD_LOAD_Y : CMD_LOAD_Z;
        v = (shape == 1) ? 32'h8000_0000 : -$urandom_range(0, 1 << 24);
        for (n = 0; n < 16; n++)
        begin
            if (shape == 2)
                v = $urandom;
            else if (shape == 1 && n == 15)
                v = 32'h7fff_ffff;
            load(c, n, $urandom, $urandom, v);
            if ($urandom_range(0, 9) != 0)
                v = v + ((shape == 1) ? $urandom_range(1, 1 << 26) : $urandom_range(1, 1 << 20));
        end
    endtask

    function automatic logic [31:0] coord(input int ax);
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom;
            3, 4: return axis_copy[ax][$urandom_range(0, 15)];
            default: return axis_copy[ax][$urandom_range(0, 15)] + $urandom_range(0, 1 << 20);
        endcase
    endfunction

    function automatic logic [31:0] cell_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 32'h8000_0000;
        if (pick == 1)
            return 32'h7fff_ffff;
        if (pick < 5)
            return $urandom_range(0, 1 << 22) - (1 << 21);
        return $urandom;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [4:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= data;
        forever
        begin
            #1;
            if (cfg_if.ready)
                break;
            @(negedge clk);
        end
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic settle();
        req_if.valid <= 1'b0;
        wait (pending_count == 0);
        @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    initial
    begin
        int n;
        int p;
        int r;
        cycle_count = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.command = CMD_QUERY;
        req_if.index_i = '0;
        req_if.index_j = '0;
        req_if.index_k = '0;
        req_if.load_value = '0;
        req_if.query_x = '0;
        req_if.query_y = '0;
        req_if.query_z = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_X_POINTS;
        cfg_if.data = '0;
        rsp_if.ready = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (n = 0; n < 3; n++)
            fill_axis(n, 0);
        for (n = 0; n < 4096; n++)
            load(CMD_LOAD_CELL, n[11:8], n[7:4], n[3:0], cell_value());

        load(CMD_LOAD_CELL, 0, 0, 0, 32'h8000_0000);
        load(CMD_LOAD_CELL, 1, 0, 0, 32'h7fff_ffff);
        load(CMD_LOAD_CELL, 15, 15, 15, 32'h7fff_ffff);
        load(CMD_LOAD_CELL, 14, 14, 14, 32'h8000_0000);
        query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        query(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        query(axis_copy[0][0], axis_copy[1][15], axis_copy[2][7]);
        query(axis_copy[0][0] + 32'h8000, axis_copy[1][0] + 1, axis_copy[2][0] + 32'hffff);
        query(axis_copy[0][14] + 32'h8000, axis_copy[1][14] + 32'h100, axis_copy[2][14] + 3);
        send(CMD_FIRST_UNUSED, 1, 2, 3, $urandom, $urandom, $urandom, $urandom);
        send(CMD_MID_UNUSED, 4, 5, 6, $urandom, $urandom, $urandom, $urandom);
        send(CMD_LAST_UNUSED, 15, 15, 15, $urandom, $urandom, $urandom, $urandom);
        load(CMD_LOAD_X, 15, 0, 0, 32'h7fff_ffff);
        load(CMD_LOAD_Y, 0, 0, 0, 32'h8000_0000);
        load(CMD_LOAD_Z, 9, 0, 0, axis_copy[2][8]);
        query(axis_copy[0][15], axis_copy[1][0], axis_copy[2][9]);
        query(32'h7fff_ffff, axis_copy[1][1] - 1, axis_copy[2][8]);
        fill_axis(0, 1);
        query(32'h0000_0000, coord(1), coord(2));
        query(32'h8000_0001, coord(1), coord(2));

        for (p = 0; p < PHASES; p++)
        begin
            settle();
            case (p)
                0: begin write_reg(REG_X_POINTS, 16); write_reg(REG_Y_POINTS, 16);
                         write_reg(REG_Z_POINTS, 16); end
                1: begin write_reg(REG_X_POINTS, 2); write_reg(REG_Y_POINTS, 2);
                         write_reg(REG_Z_POINTS, 2); end
                2: begin write_reg(REG_X_POINTS, 0); write_reg(REG_Y_POINTS, 1);
                         write_reg(REG_Z_POINTS, 31); write_reg(REG_UNUSED, 5); end
                3: begin write_reg(REG_X_POINTS, 16); write_reg(REG_Y_POINTS, 17);
                         write_reg(REG_Z_POINTS, 9); end
                default: begin write_reg(REG_X_POINTS, $urandom); write_reg(REG_Y_POINTS, $urandom);
                               write_reg(REG_Z_POINTS, $urandom); end
            endcase
            calm = (p == 4);
            for (n = 0; n < 3; n++)
                fill_axis(n, ($urandom_range(0, 9) == 0) ? 2 : ($urandom_range(0, 4) == 0) ? 1 : 0);
            for (n = 0; n < 75; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    query(coord(0), coord(1), coord(2));
                else if (r < 85)
                    load(CMD_LOAD_CELL, $urandom, $urandom, $urandom, cell_value());
                else if (r < 95)
                    load($urandom_range(0, 2), $urandom, $urandom, $urandom,
                         ($urandom_range(0, 1) == 0) ? $urandom : coord(0));
                else
                    send($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED), $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom, $urandom);
            end
            calm = 1'b0;
        end

        req_if.valid <= 1'b0;
        wait (pending_count == 0);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/tgi_pkg.sv
rtl/core/tgi_if.sv
rtl/core/tgi_front.sv
rtl/core/tgi_fifo.sv
rtl/core/tgi_back.sv
rtl/core/trilinear_grid_interpolator_unit.sv
test/tgi_checker.sv
test/tb.sv
